[src/etwi_pkg.sv]
package etwi_pkg;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_DIV  = 6'b000010,
      ST_MUL  = 6'b000100,
      ST_SCL  = 6'b001000,
      ST_FIN  = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   typedef enum logic [3:0] {
      MODE_LINEAR     = 4'd0,
      MODE_IN_QUAD    = 4'd1,
      MODE_OUT_QUAD   = 4'd2,
      MODE_INOUT_QUAD = 4'd3,
      MODE_IN_CUBIC   = 4'd4,
      MODE_OUT_CUBIC  = 4'd5,
      MODE_INOUT_CUB  = 4'd6,
      MODE_ARC        = 4'd7,
      MODE_OUT_BACK   = 4'd8
   } mode_type;

   typedef enum logic [1:0] {
      REG_START    = 2'd0,
      REG_END      = 2'd1,
      REG_DURATION = 2'd2,
      REG_MODE     = 2'd3
   } reg_type;

   localparam int DUR_WIDTH  = 24;
   localparam int VAL_WIDTH  = 32;
   localparam int STEP_WIDTH = 16;

endpackage

[src/eased_tween_interpolator.sv]
// Channel   Ports                                       Direction
// request   req_valid/ready, time_step, restart         in
// response  rsp_valid/ready, value, progress, finished  out
// csr       APB: psel penable pwrite paddr pwdata       in/out
// From one acceptance to the next, a request passes a state update, the restoring divider for
// progress, up to four curve products of the shared multiplier, the scaling product, the final
// sum (which waits while a stalled response is still held) and the return to idle. A request
// that leaves progress at one skips the divider entirely.
// Reset is synchronous and returns the configuration, the tween state and the handshake.
// A stalled response holds; the next request is taken once the result is registered.
module eased_tween_interpolator
   import etwi_pkg::*;
#(
   parameter int TIME_WIDTH = 24,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [STEP_WIDTH-1:0]        req_time_step,
   input  logic                         req_restart,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [VAL_WIDTH-1:0]  rsp_value,
   output logic [FRAC_BITS:0]           rsp_progress,
   output logic                         rsp_finished,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [3:0]                   paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);

   localparam int OW = FRAC_BITS + 4;
   localparam int DW = VAL_WIDTH + 1;
   localparam int PW = DW + OW;
   localparam int CW = $clog2(FRAC_BITS + 1);
   localparam logic [63:0] C1_RAW = ((64'd170158 << FRAC_BITS) + 64'd50000) / 64'd100000;
   localparam logic signed [OW-1:0] QONE = OW'(64'd1 << FRAC_BITS);
   localparam logic signed [OW-1:0] C1 = OW'(C1_RAW);
   localparam logic [32:0] TMASK = (33'd1 << TIME_WIDTH) - 33'd1;

   state_type state_ff, state_in;
   logic signed [VAL_WIDTH-1:0] start_ff, end_ff;
   logic [DUR_WIDTH-1:0] dur_ff;
   logic [3:0] mode_ff;
   logic [TIME_WIDTH-1:0] elapsed_ff, elapsed_in;
   logic done_ff, done_in;
   logic [TIME_WIDTH:0] rem_ff, rem_in;
   logic [FRAC_BITS:0] tq_ff, tq_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [1:0] mstep_ff, mstep_in;
   logic signed [OW-1:0] m_ff [4];
   logic signed [PW-1:0] prod_ff;
   logic rsp_valid_ff;
   logic signed [VAL_WIDTH-1:0] value_ff;
   logic [FRAC_BITS:0] prog_ff;
   logic fin_ff;

   logic [TIME_WIDTH-1:0] deff;
   logic [32:0] dur33, sum33;
   logic [TIME_WIDTH+1:0] r2;
   logic signed [OW-1:0] t_s, u_s, u6_s, e_s, opa, opb;
   logic signed [DW-1:0] mul_a;
   logic signed [PW-1:0] mul_p, rnd_p;
   logic signed [OW-1:0] qres;
   logic [1:0] nsteps;
   logic low_half, wr_en;
   logic signed [PW-1:0] sumv;
   logic signed [VAL_WIDTH-1:0] final_val;

   assign pready = 1'b1;
   assign wr_en = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         end_ff   <= '0;
         dur_ff   <= DUR_WIDTH'(1);
         mode_ff  <= '0;
      end else if (wr_en) begin
         unique case (reg_type'(paddr[3:2]))
            REG_START:    start_ff <= pwdata;
            REG_END:      end_ff   <= pwdata;
            REG_DURATION: dur_ff   <= pwdata[DUR_WIDTH-1:0];
            REG_MODE:     mode_ff  <= pwdata[3:0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_type'(paddr[3:2]))
         REG_START:    prdata = start_ff;
         REG_END:      prdata = end_ff;
         REG_DURATION: prdata = 32'(dur_ff);
         REG_MODE:     prdata = 32'(mode_ff);
         default:      prdata = '0;
      endcase
   end

   always_comb begin
      dur33 = 33'(dur_ff);
      if (dur33 == 33'd0) dur33 = 33'd1;
      if (dur33 > TMASK) dur33 = TMASK;
      deff = dur33[TIME_WIDTH-1:0];
      sum33 = 33'(elapsed_ff) + 33'(req_time_step);
   end

   // Curve operands for each multiplier step, the step count per mode and the eased curve value.
   always_comb begin
      t_s = OW'(tq_ff);
      u_s = t_s - QONE;
      u6_s = (t_s <<< 1) - (QONE <<< 1);
      low_half = t_s < (QONE >>> 1);
      opa = t_s;
      opb = t_s;
      unique case (mstep_ff)
         2'd0: begin
            unique case (mode_ff)
               MODE_OUT_QUAD: opb = (QONE <<< 1) - t_s;
               MODE_INOUT_QUAD: if (!low_half) opa = (QONE <<< 2) - (t_s <<< 1);
               MODE_OUT_CUBIC, MODE_OUT_BACK: begin
                  opa = u_s;
                  opb = u_s;
               end
               MODE_INOUT_CUB: if (!low_half) begin
                  opa = u6_s;
                  opb = u6_s;
               end
               MODE_ARC: opb = QONE - t_s;
               default: ;
            endcase
         end
         2'd1: begin
            opa = m_ff[0];
            unique case (mode_ff)
               MODE_OUT_CUBIC, MODE_OUT_BACK: opb = u_s;
               MODE_INOUT_CUB: opb = low_half ? t_s : u6_s;
               default: opb = t_s;
            endcase
         end
         2'd2: begin
            opa = C1 + QONE;
            opb = m_ff[1];
         end
         default: begin
            opa = C1;
            opb = m_ff[0];
         end
      endcase
      unique case (mode_ff)
         MODE_IN_QUAD, MODE_OUT_QUAD, MODE_INOUT_QUAD, MODE_ARC: nsteps = 2'd0;
         MODE_IN_CUBIC, MODE_OUT_CUBIC, MODE_INOUT_CUB: nsteps = 2'd1;
         MODE_OUT_BACK: nsteps = 2'd3;
         default: nsteps = 2'd0;
      endcase
      unique case (mode_ff)
         MODE_IN_QUAD, MODE_OUT_QUAD: e_s = m_ff[0];
         MODE_INOUT_QUAD: e_s = low_half ? (m_ff[0] <<< 1) : (m_ff[0] - QONE);
         MODE_IN_CUBIC: e_s = m_ff[1];
         MODE_OUT_CUBIC: e_s = m_ff[1] + QONE;
         MODE_INOUT_CUB: e_s = low_half ? (m_ff[1] <<< 2)
                                        : (((m_ff[1] + OW'(1)) >>> 1) + QONE);
         MODE_ARC: e_s = m_ff[0] <<< 2;
         MODE_OUT_BACK: e_s = QONE + m_ff[2] + m_ff[3];
         default: e_s = t_s;
      endcase
   end

   // Shared multiplier: curve products in ST_MUL, the scaling product in ST_SCL; also the rounded, saturated final sum.
   always_comb begin
      mul_a = state_ff == ST_SCL ? (DW'(end_ff) - DW'(start_ff)) : DW'(opa);
      mul_p = PW'(mul_a) * PW'(state_ff == ST_SCL ? e_s : opb);
      rnd_p = (mul_p + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      qres = rnd_p[OW-1:0];
      sumv = (prod_ff + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      sumv = sumv + PW'(start_ff);
      if (sumv > PW'(32'sh7FFFFFFF)) final_val = 32'sh7FFFFFFF;
      else if (sumv < -(PW'(64'sh80000000))) final_val = 32'sh80000000;
      else final_val = sumv[VAL_WIDTH-1:0];
      r2 = {rem_ff, 1'b0};
   end

   assign req_ready = state_ff == ST_IDLE;

   always_comb begin
      state_in = state_ff;
      elapsed_in = elapsed_ff;
      done_in = done_ff;
      rem_in = rem_ff;
      tq_in = tq_ff;
      cnt_in = cnt_ff;
      mstep_in = mstep_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_restart) begin
                  elapsed_in = '0;
                  done_in = 1'b0;
               end else if (!done_ff) begin
                  if (sum33 >= 33'(deff)) begin
                     elapsed_in = deff;
                     done_in = 1'b1;
                  end else begin
                     elapsed_in = sum33[TIME_WIDTH-1:0];
                  end
               end
               rem_in = (TIME_WIDTH+1)'(elapsed_in);
               tq_in = '0;
               cnt_in = '0;
               mstep_in = '0;
               if (elapsed_in >= deff) begin
                  tq_in = (FRAC_BITS+1)'(QONE);
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (r2 >= (TIME_WIDTH+2)'(deff)) begin
               rem_in = (TIME_WIDTH+1)'(r2 - (TIME_WIDTH+2)'(deff));
               tq_in = {tq_ff[FRAC_BITS-1:0], 1'b1};
            end else begin
               rem_in = r2[TIME_WIDTH:0];
               tq_in = {tq_ff[FRAC_BITS-1:0], 1'b0};
            end
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(FRAC_BITS - 1)) begin
               if (tq_in == '0) state_in = ST_FIN;
               else if (mode_ff == MODE_LINEAR || mode_ff > MODE_OUT_BACK) state_in = ST_SCL;
               else state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            mstep_in = mstep_ff + 2'd1;
            if (mstep_ff == nsteps) state_in = ST_SCL;
         end
         ST_SCL: state_in = ST_FIN;
         ST_FIN: if (!rsp_valid_ff || rsp_ready) state_in = ST_OUT;
         ST_OUT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         elapsed_ff <= '0;
         done_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         elapsed_ff <= elapsed_in;
         done_ff <= done_in;
         if (state_ff == ST_FIN && (!rsp_valid_ff || rsp_ready)) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      tq_ff <= tq_in;
      cnt_ff <= cnt_in;
      mstep_ff <= mstep_in;
      if (state_ff == ST_MUL) m_ff[mstep_ff] <= qres;
      if (state_ff == ST_SCL) prod_ff <= mul_p;
      if (state_ff == ST_FIN && (!rsp_valid_ff || rsp_ready)) begin
         if (tq_ff == '0) value_ff <= start_ff;
         else if (tq_ff >= (FRAC_BITS+1)'(QONE)) value_ff <= end_ff;
         else value_ff <= final_val;
         prog_ff <= tq_ff;
         fin_ff <= done_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = value_ff;
   assign rsp_progress = prog_ff;
   assign rsp_finished = fin_ff;

endmodule

[tb/eased_tween_interpolator_test.sv]
module eased_tween_interpolator_test;
   import etwi_pkg::*;

   localparam longint QONE = 64'sd65536;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct {
      logic signed [31:0] value;
      logic [16:0]        progress;
      logic               finished;
   } tween_result_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [STEP_WIDTH-1:0] req_time_step;
   logic req_restart;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [VAL_WIDTH-1:0] rsp_value;
   logic [16:0] rsp_progress;
   logic rsp_finished;
   logic psel;
   logic penable;
   logic pwrite;
   logic [3:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   tween_result_type expected_results[$];
   int errors = 0;
   int cycles = 0;
   int burst_left = 0;
   int stall_mode = 0;

   longint start_q, end_q;
   longint duration_q;
   logic [3:0] curve_q;
   longint elapsed_q;
   logic finished_q;

   eased_tween_interpolator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_time_step(req_time_step), .req_restart(req_restart),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_value(rsp_value), .rsp_progress(rsp_progress), .rsp_finished(rsp_finished),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   function automatic longint qmul(longint a, longint b);
      return (a * b + 64'sd32768) >>> 16;
   endfunction

   function automatic longint curve_point(logic [3:0] m, longint t);
      longint u, u2, c1;
      c1 = ((64'sd170158 << 16) + 64'sd50000) / 64'sd100000;
      case (m)
         MODE_IN_QUAD: return qmul(t, t);
         MODE_OUT_QUAD: return qmul(t, 2 * QONE - t);
         MODE_INOUT_QUAD: begin
            if (t < QONE / 2) return 2 * qmul(t, t);
            return qmul(4 * QONE - 2 * t, t) - QONE;
         end
         MODE_IN_CUBIC: return qmul(qmul(t, t), t);
         MODE_OUT_CUBIC: begin
            u = t - QONE;
            return qmul(qmul(u, u), u) + QONE;
         end
         MODE_INOUT_CUB: begin
            if (t < QONE / 2) return 4 * qmul(qmul(t, t), t);
            u = 2 * t - 2 * QONE;
            return ((qmul(qmul(u, u), u) + 1) >>> 1) + QONE;
         end
         MODE_ARC: return 4 * qmul(t, QONE - t);
         MODE_OUT_BACK: begin
            u = t - QONE;
            u2 = qmul(u, u);
            return QONE + qmul(c1 + QONE, qmul(u2, u)) + qmul(c1, u2);
         end
         default: return t;
      endcase
   endfunction

   function automatic tween_result_type advance_tween(logic [15:0] step, logic restart);
      tween_result_type r;
      longint d, tq, v;
      d = (duration_q == 0) ? 1 : duration_q;
      if (restart) begin
         elapsed_q = 0;
         finished_q = 1'b0;
      end else if (!finished_q) begin
         if (elapsed_q + step >= d) begin
            elapsed_q = d;
            finished_q = 1'b1;
         end else begin
            elapsed_q = elapsed_q + step;
         end
      end
      tq = (elapsed_q << 16) / d;
      if (tq > QONE) tq = QONE;
      if (tq == 0) begin
         v = start_q;
      end else if (tq >= QONE) begin
         v = end_q;
      end else begin
         v = start_q + (((end_q - start_q) * curve_point(curve_q, tq) + 64'sd32768) >>> 16);
         if (v > 64'sd2147483647) v = 64'sd2147483647;
         if (v < -64'sd2147483648) v = -64'sd2147483648;
      end
      r.value = v[31:0];
      r.progress = tq[16:0];
      r.finished = finished_q;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch in %s: got %0d, expected %0d at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   task automatic check_response();
      tween_result_type want;
      if (expected_results.size() == 0) begin
         report_mismatch("response with nothing expected", rsp_value, 0);
      end else begin
         want = expected_results.pop_front();
         if (rsp_value !== want.value) report_mismatch("value", rsp_value, want.value);
         if (rsp_progress !== want.progress)
            report_mismatch("progress", rsp_progress, want.progress);
         if (rsp_finished !== want.finished)
            report_mismatch("finished", rsp_finished, want.finished);
      end
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("eased_tween_interpolator_test: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (cycles % 300 == 0) stall_mode = $urandom_range(0, 2);
      if (!reset && rsp_valid && rsp_ready) check_response();
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= $urandom_range(0, 1);
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   task automatic send_request(logic [15:0] step, logic restart);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 20);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 30);
      end
      req_valid <= 1'b1;
      req_time_step <= step;
      req_restart <= restart;
      do @(posedge clock); while (!req_ready);
      expected_results.push_back(advance_tween(step, restart));
      burst_left--;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_register(reg_type idx, logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_START: start_q = longint'(signed'(data));
         REG_END: end_q = longint'(signed'(data));
         REG_DURATION: duration_q = data[23:0];
         default: curve_q = data[3:0];
      endcase
   endtask

   task automatic test_reset_state();
      send_request(16'd0, 1'b0);
      send_request(16'd1, 1'b0);
      send_request(16'd5, 1'b0);
      send_request(16'hFFFF, 1'b1);
      wait_idle();
   endtask

   task automatic test_every_curve();
      write_register(REG_START, 32'h8000_0000);
      write_register(REG_END, 32'h7FFF_FFFF);
      write_register(REG_DURATION, 32'd1000);
      for (int m = 0; m <= 8; m++) begin
         write_register(REG_MODE, 32'(m));
         send_request(16'hFFFF, 1'b1);
         send_request(16'd300 + 16'(m * 40), 1'b0);
         wait_idle();
      end
      write_register(REG_MODE, 32'd15);
      send_request(16'd200, 1'b0);
      send_request(16'd0, 1'b0);
      wait_idle();
   endtask

   task automatic test_random_tweens();
      int sel;
      longint step_top;
      for (int phase = 0; phase < 14; phase++) begin
         sel = $urandom_range(0, 5);
         write_register(REG_START, sel == 0 ? 32'h8000_0000 : sel == 1 ? 32'h7FFF_FFFF
                                   : $urandom);
         sel = $urandom_range(0, 5);
         write_register(REG_END, sel == 0 ? 32'h8000_0000 : sel == 1 ? 32'h7FFF_FFFF
                                 : $urandom);
         sel = $urandom_range(0, 9);
         if (sel == 0) write_register(REG_DURATION, {8'($urandom_range(0, 255)), 24'd0});
         else if (sel == 1) write_register(REG_DURATION, 32'hFFFF_FFFF);
         else if (sel == 2) write_register(REG_DURATION, $urandom);
         else write_register(REG_DURATION, $urandom_range(1, 300));
         write_register(REG_MODE, $urandom_range(0, 15));
         if ($urandom_range(0, 2) != 0) send_request(16'($urandom), 1'b1);
         step_top = ((duration_q == 0 ? 1 : duration_q) / 8) + 1;
         if (step_top > 65535) step_top = 65535;
         for (int k = 0; k < 90; k++) begin
            sel = $urandom_range(0, 19);
            if (sel == 0) send_request(16'($urandom), 1'b1);
            else if (sel < 3 || (finished_q && sel < 8)) send_request(16'($urandom), sel < 3);
            else send_request(16'($urandom_range(0, int'(step_top))), 1'b0);
         end
         wait_idle();
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_time_step <= '0;
      req_restart <= 1'b0;
      rsp_ready <= 1'b0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      start_q = 0;
      end_q = 0;
      duration_q = 1;
      curve_q = '0;
      elapsed_q = 0;
      finished_q = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_every_curve();
      test_random_tweens();
      wait_idle();
      if (errors == 0) begin
         $display("eased_tween_interpolator_test: PASS");
      end else begin
         $display("eased_tween_interpolator_test: FAIL");
      end
      $finish;
   end

endmodule
